[hw/rtl/tmp_pkg.sv]
// Shared constants, types and helpers for the trapezoidal motion profile block.
`default_nettype none

package tmp_pkg;

  // Field and datapath widths
  localparam int VAL_W      = 24;              // signed Q8.16 position / velocity
  localparam int VLIM_W     = 23;              // unsigned velocity limit
  localparam int DT_W       = 16;              // unsigned Q0.16 control period
  localparam int ACC_W      = 23;              // unsigned Q7.16 acceleration limit
  localparam int ROOT_W     = 24;              // stopping speed root width
  localparam int RAD_W      = 2 * ROOT_W;      // radicand 2*a*|e|
  localparam int MUL_A_W    = VAL_W + 1;       // shared multiplier, first operand
  localparam int MUL_B_W    = VAL_W;           // shared multiplier, second operand
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ITER_W     = $clog2(ROOT_W);

  // Stream payload widths
  localparam int IN_DATA_W  = ((VAL_W + VLIM_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * VAL_W + 7) / 8) * 8;

  // Deadband: |error| * 10000 < 2^FRAC_BITS  <=>  |error| < ceil(2^FRAC_BITS / 10000)
  localparam int FRAC_BITS  = 16;
  localparam int DB_LIMIT   = ((1 << FRAC_BITS) + 9999) / 10000;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_TIME   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_LIMIT = 1'b1;
  localparam logic [DT_W-1:0]       STEP_TIME_RST   = 16'd655;
  localparam logic [ACC_W-1:0]      ACCEL_LIMIT_RST = 23'd32768;

  // Input opcodes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic take_item;   // latch a new input transaction
    logic snap;        // position to target, velocity to zero
    logic mul_stop;    // radicand = 2 * accel * |error|
    logic mul_dv;      // dv_max = accel * dt >> 16
    logic sqrt_start;  // launch the square root
    logic calc_vel;    // new clamped velocity
    logic mul_pos;     // position step = vel * dt >> 16
    logic commit;      // integrate position, check overshoot
    logic load_out;    // capture result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op_reset;
    logic dt_zero;
    logic deadband;
    logic sqrt_done;
  } status_t;

  // Saturate a value with three guard bits to the signed VAL_W range
  function automatic logic [VAL_W-1:0] sat_val(input logic [VAL_W+2:0] v);
    logic [VAL_W-1:0] r;
    if ((&v[VAL_W+2:VAL_W-1]) || !(|v[VAL_W+2:VAL_W-1])) begin
      r = v[VAL_W-1:0];
    end else if (v[VAL_W+2]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tmp_isqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none

module tmp_isqrt (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start_i,
  input  wire [tmp_pkg::RAD_W-1:0]  radicand_i,
  output logic                      done_o,
  output logic [tmp_pkg::ROOT_W-1:0] root_o
);

  localparam int RW = tmp_pkg::ROOT_W;

  logic [tmp_pkg::RAD_W-1:0]  rad_r, rad_nxt;
  logic [RW:0]                rem_r, rem_nxt;
  logic [RW-1:0]              root_r, root_nxt;
  logic [tmp_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;

  // Bring down two radicand bits, try to subtract 4*root+1
  always_comb begin
    rem_sh   = {rem_r, rad_r[tmp_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i && !busy_r) begin
      rad_nxt  = radicand_i;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = tmp_pkg::ITER_W'(RW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[tmp_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = (RW + 1)'(rem_sh - trial);
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[RW:0];
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold iteration state
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done_o = done_r;
  assign root_o = root_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start_i && !busy_r) |=> busy_r)
    else $error("square root did not start");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0) |=> (done_r && !busy_r))
    else $error("square root did not finish after its last iteration");

endmodule

`default_nettype wire

[hw/rtl/tmp_datapath.sv]
// Profile datapath: configuration, state, shared multiplier, velocity and position update.
`default_nettype none

module tmp_datapath (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [tmp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [tmp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire [tmp_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire                             in_tuser,
  input  wire tmp_pkg::cmd_t              cmd_i,
  output tmp_pkg::status_t                status_o,
  output logic [tmp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser
);

  localparam int VW = tmp_pkg::VAL_W;

  // Configuration registers
  logic [tmp_pkg::DT_W-1:0]  step_time_r;
  logic [tmp_pkg::ACC_W-1:0] accel_r;

  // Profile state and item registers
  logic [VW-1:0]               pos_r, vel_r;
  logic [VW-1:0]               target_r;
  logic [tmp_pkg::VLIM_W-1:0]  vlim_r;
  logic                        op_r;
  logic [VW-1:0]               mag_r;
  logic                        dir_neg_r;
  logic [tmp_pkg::RAD_W-1:0]   rad_r;
  logic [tmp_pkg::ACC_W-1:0]   dvmax_r;
  logic [VW-1:0]               vel_new_r;
  logic [VW:0]                 step_r;
  logic [tmp_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                        out_user_r;

  logic [VW-1:0]  in_target;
  logic [VW:0]    err;
  logic [VW:0]    err_abs;

  logic signed [tmp_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tmp_pkg::MUL_B_W-1:0] mul_b;
  logic signed [tmp_pkg::PROD_W-1:0]  prod;

  logic [tmp_pkg::ROOT_W-1:0] root;
  logic                       sqrt_done;

  logic [VW-1:0]        dmag;
  logic signed [VW+1:0] desired, dv, dv_cl, dvm_pos, dvm_neg;
  logic [VW+2:0]        vsum;
  logic signed [VW+1:0] pos_sum;
  logic signed [VW+2:0] diff;
  logic                 overshoot;

  // Error against current position for an incoming item
  assign in_target = in_tdata[VW-1:0];
  assign err       = {in_target[VW-1], in_target} - {pos_r[VW-1], pos_r};
  assign err_abs   = err[VW] ? (~err + 1'b1) : err;

  // Shared multiplier: a*|e|, a*dt, vel*dt
  always_comb begin
    if (cmd_i.mul_stop) begin
      mul_a = {1'b0, mag_r};
    end else begin
      mul_a = {{(tmp_pkg::MUL_A_W - tmp_pkg::DT_W){1'b0}}, step_time_r};
    end
    if (cmd_i.mul_pos) begin
      mul_b = vel_new_r;
    end else begin
      mul_b = {{(tmp_pkg::MUL_B_W - tmp_pkg::ACC_W){1'b0}}, accel_r};
    end
  end
  assign prod = mul_a * mul_b;

  // Desired velocity and clamped velocity change
  always_comb begin
    dmag = ({1'b0, vlim_r} < root) ? {1'b0, vlim_r} : root;
    desired = dir_neg_r ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
    dv      = desired - $signed({{2{vel_r[VW-1]}}, vel_r});
    dvm_pos = $signed({{(VW + 2 - tmp_pkg::ACC_W){1'b0}}, dvmax_r});
    dvm_neg = -dvm_pos;
    if (dv > dvm_pos) begin
      dv_cl = dvm_pos;
    end else if (dv < dvm_neg) begin
      dv_cl = dvm_neg;
    end else begin
      dv_cl = dv;
    end
    vsum = {{3{vel_r[VW-1]}}, vel_r} + {dv_cl[VW+1], dv_cl};
  end

  // Integrated position and overshoot test
  always_comb begin
    pos_sum   = $signed({{2{pos_r[VW-1]}}, pos_r}) + $signed({step_r[VW], step_r});
    diff      = $signed({{3{target_r[VW-1]}}, target_r}) - $signed({pos_sum[VW+1], pos_sum});
    overshoot = dir_neg_r ? (diff >= 0) : (diff <= 0);
  end

  tmp_isqrt u_isqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (rad_r),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= tmp_pkg::STEP_TIME_RST;
      accel_r     <= tmp_pkg::ACCEL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tmp_pkg::REG_STEP_TIME:   step_time_r <= cfg_wdata[tmp_pkg::DT_W-1:0];
        tmp_pkg::REG_ACCEL_LIMIT: accel_r     <= cfg_wdata[tmp_pkg::ACC_W-1:0];
        default: ;
      endcase
    end
  end

  // Profile state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vel_r <= '0;
    end else if (cmd_i.snap) begin
      pos_r <= target_r;
      vel_r <= '0;
    end else if (cmd_i.commit) begin
      if (overshoot) begin
        pos_r <= target_r;
        vel_r <= '0;
      end else begin
        pos_r <= tmp_pkg::sat_val({pos_sum[VW+1], pos_sum});
        vel_r <= vel_new_r;
      end
    end
  end

  // Item, intermediate and result registers
  always_ff @(posedge clk) begin
    if (cmd_i.take_item) begin
      op_r      <= in_tuser;
      target_r  <= in_target;
      vlim_r    <= in_tdata[VW +: tmp_pkg::VLIM_W];
      mag_r     <= err_abs[VW-1:0];
      dir_neg_r <= err[VW];
    end
    if (cmd_i.mul_stop) begin
      rad_r <= {prod[tmp_pkg::RAD_W-2:0], 1'b0};
    end
    if (cmd_i.mul_dv) begin
      dvmax_r <= prod[tmp_pkg::DT_W +: tmp_pkg::ACC_W];
    end
    if (cmd_i.calc_vel) begin
      vel_new_r <= tmp_pkg::sat_val(vsum);
    end
    if (cmd_i.mul_pos) begin
      step_r <= prod[tmp_pkg::DT_W +: VW + 1];
    end
    if (cmd_i.load_out) begin
      out_data_r <= {vel_r, pos_r};
      out_user_r <= (pos_r == target_r) && (vel_r == '0);
    end
  end

  always_comb begin
    status_o.op_reset  = (op_r == tmp_pkg::OP_RESET);
    status_o.dt_zero   = (step_time_r == '0);
    status_o.deadband  = ({8'd0, mag_r} < 32'(tmp_pkg::DB_LIMIT));
    status_o.sqrt_done = sqrt_done;
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  a_snap_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.snap |=> (vel_r == '0 && pos_r == $past(target_r)))
    else $error("snap did not land on target at rest");

endmodule

`default_nettype wire

[hw/rtl/tmp_ctrl.sv]
// Sequencing controller for the profile datapath and the stream handshakes.
`default_nettype none

module tmp_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire               out_tready,
  input  wire tmp_pkg::status_t status_i,
  output tmp_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MSTOP,
    S_SQRT0,
    S_SQRTW,
    S_VEL,
    S_MPOS,
    S_COMMIT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  // Decode commands and next state
  always_comb begin
    cmd_o          = '0;
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.take_item = 1'b1;
          state_nxt       = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (status_i.op_reset) begin
          cmd_o.snap = 1'b1;
          state_nxt  = S_OUT;
        end else if (status_i.dt_zero) begin
          state_nxt = S_OUT;
        end else if (status_i.deadband) begin
          cmd_o.snap = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_MSTOP;
        end
      end
      S_MSTOP: begin
        cmd_o.mul_stop = 1'b1;
        state_nxt      = S_SQRT0;
      end
      S_SQRT0: begin
        cmd_o.sqrt_start = 1'b1;
        cmd_o.mul_dv     = 1'b1;
        state_nxt        = S_SQRTW;
      end
      S_SQRTW: begin
        if (status_i.sqrt_done) begin
          state_nxt = S_VEL;
        end
      end
      S_VEL: begin
        cmd_o.calc_vel = 1'b1;
        state_nxt      = S_MPOS;
      end
      S_MPOS: begin
        cmd_o.mul_pos = 1'b1;
        state_nxt     = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load_out |-> (!out_tvalid_r || out_tready))
    else $error("result overwritten before it was taken");

  a_sqrt_window: assert property (@(posedge clk) disable iff (!rst_n)
    status_i.sqrt_done |-> (state_r == S_SQRTW))
    else $error("square root finished outside its wait state");

endmodule

`default_nettype wire

[hw/rtl/trapezoidal_motion_profile.sv]
// Top level of the trapezoidal motion profile generator.
// One axis of trapezoidal setpoints in signed Q8.16. Each input transaction is
// either a reset (tuser = 1: load position, zero velocity) or a step toward a
// target under a per-step speed limit and the configured acceleration limit;
// every transaction yields exactly one result transaction with the new position,
// velocity and an at-target flag. A reset, a step inside the deadband or a step
// with a zero period goes from evaluation straight to the result; a full step
// also takes the square root of the stopping speed, which resolves one of its
// 24 root bits per cycle. One item is worked at a time; a
// new item is accepted while the previous result is still waiting on out_tready.
// Configuration (step_time at index 0, accel_limit at index 1) is written through cfg_we /
// cfg_addr / cfg_wdata; the user must write it only while the block is idle, as the block does not enforce this.
`default_nettype none

module trapezoidal_motion_profile (
  input  wire                             clk,
  input  wire                             rst_n,
  // configuration write port
  input  wire                             cfg_we,
  input  wire [tmp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [tmp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [tmp_pkg::IN_DATA_W-1:0]    in_tdata,   // target_position[23:0], velocity_limit[46:24]
  input  wire                             in_tuser,   // opcode
  // result stream
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [tmp_pkg::OUT_DATA_W-1:0]  out_tdata,  // command_position[23:0], command_velocity[47:24]
  output logic                            out_tuser   // at_target
);

  tmp_pkg::cmd_t    cmd;
  tmp_pkg::status_t status;

  tmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tmp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

[tb/motion_profile_checker.sv]
// Checker for the trapezoidal motion profile: predicts each setpoint and compares results.
module motion_profile_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [tmp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire [tmp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                              in_tvalid,
  input  wire                              in_tready,
  input  wire [tmp_pkg::IN_DATA_W-1:0]     in_tdata,   // target_position[23:0], velocity_limit[46:24]
  input  wire                              in_tuser,   // opcode
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  input  wire [tmp_pkg::OUT_DATA_W-1:0]    out_tdata,  // command_position[23:0], command_velocity[47:24]
  input  wire                              out_tuser,  // at_target
  output int                               mismatch_count,
  output int                               backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VAL_W     = tmp_pkg::VAL_W;
  localparam int VLIM_W    = tmp_pkg::VLIM_W;
  localparam int DT_W      = tmp_pkg::DT_W;
  localparam int ACC_W     = tmp_pkg::ACC_W;
  localparam int ROOT_W    = tmp_pkg::ROOT_W;
  localparam int FRAC_BITS = tmp_pkg::FRAC_BITS;

  localparam longint POS_MAX = (longint'(1) << (VAL_W - 1)) - 1;
  localparam longint POS_MIN = -(longint'(1) << (VAL_W - 1));

  typedef struct packed {
    logic signed [VAL_W-1:0] position;
    logic signed [VAL_W-1:0] velocity;
    logic                    at_target;
  } setpoint_t;

  // Predicted setpoints not yet seen on the result channel, oldest first
  setpoint_t setpoint_queue[$];

  // Shadow of the commanded state and of the configuration registers
  logic signed [VAL_W-1:0] cmd_pos;
  logic signed [VAL_W-1:0] cmd_vel;
  logic [DT_W-1:0]         period;
  logic [ACC_W-1:0]        accel;

  function automatic longint clip_q8_16(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Floor of the square root, one root bit at a time from the top
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = ROOT_W; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Advance the shadow state by one transaction and return the setpoint it yields
  function automatic setpoint_t apply_item(input logic op,
                                           input logic signed [VAL_W-1:0] goal,
                                           input logic [VLIM_W-1:0] lim);
    setpoint_t sp;
    longint err, mag, dir, a_l, dt_l, desired, dv, dv_max, vel, pos;
    a_l  = longint'(accel);
    dt_l = longint'(period);
    if (op == tmp_pkg::OP_RESET) begin
      cmd_pos = goal;
      cmd_vel = '0;
    end else if (dt_l != 0) begin
      err = longint'(goal) - longint'(cmd_pos);
      mag = (err < 0) ? -err : err;
      dir = (err >= 0) ? 1 : -1;
      if (mag * 10000 < (longint'(1) << FRAC_BITS)) begin
        // deadband: settle on the target
        cmd_pos = goal;
        cmd_vel = '0;
      end else begin
        desired = longint'(floor_sqrt(2 * a_l * mag));
        if (longint'(lim) < desired) desired = longint'(lim);
        desired = dir * desired;
        dv_max  = (a_l * dt_l) >>> DT_W;
        dv      = desired - longint'(cmd_vel);
        if (dv > dv_max) dv = dv_max;
        if (dv < -dv_max) dv = -dv_max;
        vel = clip_q8_16(longint'(cmd_vel) + dv);
        pos = longint'(cmd_pos) + ((vel * dt_l) >>> DT_W);
        // reaching or passing the target snaps onto it
        if ((longint'(goal) - pos) * dir <= 0) begin
          cmd_pos = goal;
          cmd_vel = '0;
        end else begin
          cmd_pos = VAL_W'(clip_q8_16(pos));
          cmd_vel = VAL_W'(vel);
        end
      end
    end
    sp.position  = cmd_pos;
    sp.velocity  = cmd_vel;
    sp.at_target = (cmd_pos == goal) && (cmd_vel == 0);
    return sp;
  endfunction

  always @(posedge clk) begin : watch_channels
    setpoint_t want;
    setpoint_t predicted;
    logic signed [VAL_W-1:0] got_pos;
    logic signed [VAL_W-1:0] got_vel;
    if (!rst_n) begin
      period = tmp_pkg::STEP_TIME_RST;
      accel  = tmp_pkg::ACCEL_LIMIT_RST;
      cmd_pos = '0;
      cmd_vel = '0;
      setpoint_queue.delete();
      mismatch_count = 0;
    end else begin
      // compare a result transaction against the oldest prediction
      if (out_tvalid && out_tready) begin
        got_pos = out_tdata[VAL_W-1:0];
        got_vel = out_tdata[VAL_W +: VAL_W];
        if (setpoint_queue.size() == 0) begin
          $error("unexpected result transaction: command_position %0d, command_velocity %0d",
                 got_pos, got_vel);
          mismatch_count++;
        end else begin
          want = setpoint_queue.pop_front();
          if (got_pos !== want.position) begin
            $error("command_position: expected %0d, got %0d", want.position, got_pos);
            mismatch_count++;
          end
          if (got_vel !== want.velocity) begin
            $error("command_velocity: expected %0d, got %0d", want.velocity, got_vel);
            mismatch_count++;
          end
          if (out_tuser !== want.at_target) begin
            $error("at_target: expected %0d, got %0d", want.at_target, out_tuser);
            mismatch_count++;
          end
        end
      end
      // track register writes
      if (cfg_we) begin
        case (cfg_addr)
          tmp_pkg::REG_STEP_TIME:   period = cfg_wdata[DT_W-1:0];
          tmp_pkg::REG_ACCEL_LIMIT: accel  = cfg_wdata[ACC_W-1:0];
          default: ;
        endcase
      end
      // predict an accepted input transaction
      if (in_tvalid && in_tready) begin
        predicted = apply_item(in_tuser, in_tdata[VAL_W-1:0], in_tdata[VAL_W +: VLIM_W]);
        setpoint_queue.insert(setpoint_queue.size(), predicted);
      end
    end
    backlog = setpoint_queue.size();
  end

endmodule

[tb/tb.sv]
// Testbench top for the trapezoidal motion profile: stimulus, flow control and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     VAL_W         = tmp_pkg::VAL_W;
  localparam int     VLIM_W        = tmp_pkg::VLIM_W;
  localparam int     DT_W          = tmp_pkg::DT_W;
  localparam int     ACC_W         = tmp_pkg::ACC_W;
  localparam int     CFG_ADDR_W    = tmp_pkg::CFG_ADDR_W;
  localparam int     CFG_DATA_W    = tmp_pkg::CFG_DATA_W;
  localparam int     IN_DATA_W     = tmp_pkg::IN_DATA_W;
  localparam int     OUT_DATA_W    = tmp_pkg::OUT_DATA_W;

  localparam int     CLK_PERIOD    = 10;
  localparam int     RESET_CYCLES  = 6;
  localparam int     IDLE_GAP      = 4;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     CYCLE_LIMIT   = 1000000;
  localparam int     HOLD_AFTER    = 500;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     PHASES        = 10;
  localparam longint POS_MAX       = (longint'(1) << (VAL_W - 1)) - 1;
  localparam longint POS_MIN       = -(longint'(1) << (VAL_W - 1));

  localparam logic [VAL_W-1:0]      VAL_HI   = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0]      VAL_LO   = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VLIM_W-1:0]     VLIM_TOP = {VLIM_W{1'b1}};
  localparam logic [CFG_DATA_W-1:0] DT_TOP   = CFG_DATA_W'({DT_W{1'b1}});
  localparam logic [CFG_DATA_W-1:0] ACC_TOP  = CFG_DATA_W'({ACC_W{1'b1}});

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;  // target_position[23:0], velocity_limit[46:24]
  logic                   in_tuser   = 1'b0; // opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;  // command_position[23:0], command_velocity[47:24]
  logic                   out_tuser;  // at_target
  int                     mismatch_count;
  int                     backlog;
  int                     cycle_count = 0;
  logic                   send_burst  = 1'b0;
  logic                   recv_burst  = 1'b0;

  trapezoidal_motion_profile dut (.*);

  motion_profile_checker checker_i (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(input logic op, input logic [VAL_W-1:0] goal,
                           input logic [VLIM_W-1:0] lim);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - VAL_W - VLIM_W){1'b0}}, lim, goal};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait for every outstanding setpoint
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // Write both registers once the block is idle
  task automatic configure(input logic [CFG_DATA_W-1:0] dt_word,
                           input logic [CFG_DATA_W-1:0] acc_word);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= tmp_pkg::REG_STEP_TIME;
    cfg_wdata <= dt_word;
    @(posedge clk);
    cfg_addr  <= tmp_pkg::REG_ACCEL_LIMIT;
    cfg_wdata <= acc_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly reset-then-move sequences toward nearby targets, some noise between them
  task automatic run_moves(input int budget);
    int                sent, run_len;
    longint            goal_l, magnitude;
    logic [VAL_W-1:0]  start, goal;
    logic [VLIM_W-1:0] lim;
    logic [31:0]       rnd;
    sent = 0;
    goal = '0;
    lim  = '0;
    while (sent < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        rnd = $urandom;
        send_item(rnd[0], VAL_W'($urandom), VLIM_W'($urandom));
        sent++;
      end else begin
        start = VAL_W'($urandom);
        send_item(tmp_pkg::OP_RESET, start, VLIM_W'($urandom));
        run_len = $urandom_range(4, 40);
        for (int k = 0; k < run_len; k++) begin
          // pick a new goal at the start and now and then mid-move
          if (k == 0 || $urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 3) == 0) begin
              goal = VAL_W'($urandom);
            end else begin
              magnitude = longint'($urandom_range(0, 1 << $urandom_range(3, 21)));
              goal_l = longint'($signed(start)) + ($urandom_range(0, 1) ? magnitude : -magnitude);
              if (goal_l > POS_MAX) goal_l = POS_MAX;
              if (goal_l < POS_MIN) goal_l = POS_MIN;
              goal = goal_l[VAL_W-1:0];
            end
            if ($urandom_range(0, 3) == 0) begin
              lim = VLIM_W'($urandom_range(0, 1 << $urandom_range(4, 20)));
            end else begin
              lim = VLIM_W'($urandom);
            end
          end
          send_item(tmp_pkg::OP_STEP, goal, lim);
        end
        sent += 1 + run_len;
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] dt_word;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: deadband edges, reset items, full-range moves
    send_item(tmp_pkg::OP_STEP, '0, '0);                // already on target at the origin
    send_item(tmp_pkg::OP_STEP, VAL_W'(6), VLIM_TOP);   // largest error inside the deadband
    send_item(tmp_pkg::OP_RESET, '0, VLIM_TOP);         // reset ignores the speed limit
    send_item(tmp_pkg::OP_STEP, VAL_W'(-6), VLIM_TOP);
    send_item(tmp_pkg::OP_RESET, '0, '0);
    send_item(tmp_pkg::OP_STEP, VAL_W'(7), VLIM_TOP);   // smallest error outside the deadband
    send_item(tmp_pkg::OP_STEP, VAL_W'(7), VLIM_TOP);
    send_item(tmp_pkg::OP_RESET, '0, '0);
    send_item(tmp_pkg::OP_STEP, VAL_W'(-7), VLIM_TOP);
    send_item(tmp_pkg::OP_RESET, VAL_HI, '0);
    send_item(tmp_pkg::OP_RESET, VAL_LO, VLIM_TOP);
    send_item(tmp_pkg::OP_STEP, VAL_HI, VLIM_TOP);      // longest possible move
    send_item(tmp_pkg::OP_STEP, VAL_HI, '0);            // zero speed limit brakes
    send_item(tmp_pkg::OP_STEP, VAL_LO, VLIM_W'(1));

    // Fastest settings: velocity jumps to its limit and overshoots snap
    configure(DT_TOP, ACC_TOP);
    send_item(tmp_pkg::OP_RESET, '0, '0);
    send_item(tmp_pkg::OP_STEP, VAL_HI, VLIM_TOP);
    send_item(tmp_pkg::OP_STEP, VAL_LO, VLIM_TOP);
    send_item(tmp_pkg::OP_STEP, VAL_LO, VLIM_TOP);
    send_item(tmp_pkg::OP_STEP, '0, VLIM_TOP);

    // Zero period freezes motion, even inside the deadband
    configure('0, CFG_DATA_W'(tmp_pkg::ACCEL_LIMIT_RST));
    send_item(tmp_pkg::OP_STEP, VAL_W'(1000), VLIM_TOP);
    send_item(tmp_pkg::OP_STEP, VAL_W'(3), VLIM_TOP);
    send_item(tmp_pkg::OP_RESET, VAL_W'(-5000), '0);

    // Random phases, the first ones at extreme settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: configure(DT_TOP, ACC_TOP);
        1: configure('0, CFG_DATA_W'($urandom));
        2: configure(CFG_DATA_W'(1), '0);
        3: configure(DT_TOP, CFG_DATA_W'(1));
        default: begin
          dt_word = CFG_DATA_W'($urandom);
          dt_word[DT_W-1:0] = DT_W'($urandom_range(1000, 8000));
          configure(dt_word, CFG_DATA_W'($urandom_range(1 << 18, 1 << 22)));
        end
      endcase
      run_moves((ph < 4) ? 100 : 250);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random stalls, bursts without stalls, one long hold-off
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      if (taken == HOLD_AFTER) stall = HOLD_CYCLES;
      else if (recv_burst) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // Abort a run that hangs
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
